@@ hw/rtl/uttr_pkg.sv @@
// shared types, constants and helpers for the uart ring buffer engine
// no dependencies; imported by the top level and uttr_ctrl

package uttr_pkg;

    localparam int TX_DEPTH = 64;
    localparam int RX_DEPTH = 64;
    localparam int TX_AW    = $clog2(TX_DEPTH);
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int TX_FW    = $clog2(TX_DEPTH + 1);
    localparam int RX_FW    = $clog2(RX_DEPTH + 1);
    localparam int BYTE_W   = 8;
    localparam int LEVEL_W  = 7;
    localparam int OUT_W    = 40;

    typedef enum logic [1:0] {
        OP_HOST_WRITE = 2'd0,
        OP_TX_DONE    = 2'd1,
        OP_RX_BYTE    = 2'd2,
        OP_HOST_READ  = 2'd3
    } op_t;

    typedef struct packed {
        logic              we;
        logic [TX_AW-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [TX_AW-1:0]  raddr;
    } tx_mem_req_t;

    typedef struct packed {
        logic              we;
        logic [RX_AW-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [RX_AW-1:0]  raddr;
    } rx_mem_req_t;

    // request state held while the ring read completes
    typedef struct packed {
        logic               line_valid;
        logic               tx_fwd;
        logic [BYTE_W-1:0]  fwd_byte;
        logic               accepted;
        logic               rd_pop;
        logic [LEVEL_W-1:0] tx_level;
        logic [LEVEL_W-1:0] rx_level;
        logic               tx_busy;
    } stage_t;

    typedef struct packed {
        logic               tx_busy;
        logic [LEVEL_W-1:0] rx_level;
        logic [LEVEL_W-1:0] tx_level;
        logic [BYTE_W-1:0]  read_byte;
        logic               accepted;
        logic [BYTE_W-1:0]  line_byte;
        logic               line_valid;
    } result_t;

    function automatic logic [LEVEL_W-1:0] to_level(input logic [31:0] v);
        return v[LEVEL_W-1:0];
    endfunction

endpackage

@@ hw/rtl/uart_tx_rx_ring_buffer.sv @@
// top level of the uart transmit/receive ring buffer engine
// uses uttr_pkg, uttr_ram and uttr_ctrl

// A request's ring indexes and fill counts update in the accept cycle, the
// ring ram read is issued in that cycle with registered read data returned in
// the next cycle, and the result then sits in an output register until taken.
// Throughput is one request per cycle while the result side keeps up; a stalled
// result holds at most one more request in flight before s_tready drops. Both
// rings are plain rams with no clearing pass, so requests are taken right after
// reset. A launch out of an empty transmit ring forwards the byte being written
// instead of the ram read data.

module uart_tx_rx_ring_buffer
    import uttr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // data_byte[7:0]
    input  logic [1:0]       s_tuser,   // op[1:0]
    input  logic             s_tlast,   // burst_last
    output logic             m_tvalid,
    input  logic             m_tready,
    // line_valid[0], line_byte[8:1], accepted[9], read_byte[17:10],
    // tx_level[24:18], rx_level[31:25], tx_busy[32], zero fill[39:33]
    output logic [OUT_W-1:0] m_tdata
);

    tx_mem_req_t       tx_mem;
    rx_mem_req_t       rx_mem;
    logic [BYTE_W-1:0] tx_rdata, rx_rdata;
    logic              stage_valid, stage_adv, req_fire;
    stage_t            stage;
    result_t           result_next, result_reg;
    logic              out_valid_reg, out_valid_next;

    // stage moves forward when the output register is free or being drained
    assign stage_adv = stage_valid && (!out_valid_reg || m_tready);
    assign s_tready  = !stage_valid || stage_adv;
    assign req_fire  = s_tvalid && s_tready;

    uttr_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_fire    (req_fire),
        .req_op      (op_t'(s_tuser)),
        .req_byte    (s_tdata),
        .req_last    (s_tlast),
        .stage_adv   (stage_adv),
        .tx_mem      (tx_mem),
        .rx_mem      (rx_mem),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    // transmit ring
    uttr_ram #(.WIDTH(BYTE_W), .DEPTH(TX_DEPTH)) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_mem.we),
        .waddr (tx_mem.waddr),
        .wdata (tx_mem.wdata),
        .re    (tx_mem.re),
        .raddr (tx_mem.raddr),
        .rdata (tx_rdata)
    );

    // receive ring
    uttr_ram #(.WIDTH(BYTE_W), .DEPTH(RX_DEPTH)) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_mem.we),
        .waddr (rx_mem.waddr),
        .wdata (rx_mem.wdata),
        .re    (rx_mem.re),
        .raddr (rx_mem.raddr),
        .rdata (rx_rdata)
    );

    // ram read data holds while the stage waits, since no new read is issued
    always_comb begin
        result_next.line_valid = stage.line_valid;
        if (!stage.line_valid) begin
            result_next.line_byte = '0;
        end else if (stage.tx_fwd) begin
            result_next.line_byte = stage.fwd_byte;
        end else begin
            result_next.line_byte = tx_rdata;
        end
        result_next.accepted  = stage.accepted;
        result_next.read_byte = stage.rd_pop ? rx_rdata : '0;
        result_next.tx_level  = stage.tx_level;
        result_next.rx_level  = stage.rx_level;
        result_next.tx_busy   = stage.tx_busy;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (stage_adv) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_adv) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(result_reg);

    // a byte handed to the line always leaves the transmitter busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!result_reg.line_valid || result_reg.tx_busy))
        else $error("line byte launched without busy flag");

    // fill levels never pass the ring depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(result_reg.tx_level) <= TX_DEPTH)
                  && (32'(result_reg.rx_level) <= RX_DEPTH))
        else $error("ring level beyond depth");

    // a popped byte only shows when the read was granted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result_reg.read_byte != '0) |-> result_reg.accepted)
        else $error("read byte without grant");

    // with a full stage and a stalled result no new request may enter
    assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("request taken while pipeline is full");

    // a ram read is only issued for a request that is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (tx_mem.re || rx_mem.re) |-> req_fire)
        else $error("ring read without request");

endmodule

@@ hw/rtl/uttr_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies

module uttr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/uttr_ctrl.sv @@
// ring index and fill count engine: decodes a request, drives both ring rams,
// holds the request state until the stage advances to the output register; uses uttr_pkg

module uttr_ctrl
    import uttr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_fire,
    input  op_t               req_op,
    input  logic [BYTE_W-1:0] req_byte,
    input  logic              req_last,
    input  logic              stage_adv,
    output tx_mem_req_t       tx_mem,
    output rx_mem_req_t       rx_mem,
    output logic              stage_valid,
    output stage_t            stage
);

    logic [TX_AW-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [RX_AW-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [TX_FW-1:0] tx_fill_reg, tx_fill_next, tx_fill_pushed;
    logic [RX_FW-1:0] rx_fill_reg, rx_fill_next;
    logic             sending_reg, sending_next;
    logic             stage_valid_reg, stage_valid_next;
    stage_t           stage_reg, stage_next;

    logic [TX_AW-1:0] tx_head_inc, tx_tail_inc;
    logic [RX_AW-1:0] rx_head_inc, rx_tail_inc;
    logic             tx_push, tx_pop, rx_push, rx_pop;

    assign tx_head_inc = (tx_head_reg == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_reg + TX_AW'(1);
    assign tx_tail_inc = (tx_tail_reg == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_reg + TX_AW'(1);
    assign rx_head_inc = (rx_head_reg == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_reg + RX_AW'(1);
    assign rx_tail_inc = (rx_tail_reg == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail_reg + RX_AW'(1);

    always_comb begin
        tx_push      = 1'b0;
        tx_pop       = 1'b0;
        rx_push      = 1'b0;
        rx_pop       = 1'b0;
        sending_next = sending_reg;
        tx_fill_pushed = tx_fill_reg;
        if (req_fire) begin
            case (req_op)
                OP_HOST_WRITE: begin
                    tx_push = (tx_fill_reg != TX_FW'(TX_DEPTH));
                    tx_fill_pushed = tx_fill_reg + TX_FW'(tx_push);
                    if (req_last && !sending_reg && (tx_fill_pushed != '0)) begin
                        tx_pop       = 1'b1;
                        sending_next = 1'b1;
                    end
                end
                OP_TX_DONE: begin
                    tx_pop       = (tx_fill_reg != '0);
                    sending_next = tx_pop;
                end
                OP_RX_BYTE: begin
                    rx_push = (rx_fill_reg != RX_FW'(RX_DEPTH));
                end
                OP_HOST_READ: begin
                    rx_pop = (rx_fill_reg != '0);
                end
                default: begin
                    tx_push = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        tx_head_next = tx_push ? tx_head_inc : tx_head_reg;
        tx_tail_next = tx_pop ? tx_tail_inc : tx_tail_reg;
        rx_head_next = rx_push ? rx_head_inc : rx_head_reg;
        rx_tail_next = rx_pop ? rx_tail_inc : rx_tail_reg;
        tx_fill_next = tx_fill_reg + TX_FW'(tx_push) - TX_FW'(tx_pop);
        rx_fill_next = rx_fill_reg + RX_FW'(rx_push) - RX_FW'(rx_pop);
    end

    // ram requests go out in the accept cycle, index state is already current
    always_comb begin
        tx_mem.we    = tx_push;
        tx_mem.waddr = tx_head_reg;
        tx_mem.wdata = req_byte;
        tx_mem.re    = tx_pop;
        tx_mem.raddr = tx_tail_reg;
        rx_mem.we    = rx_push;
        rx_mem.waddr = rx_head_reg;
        rx_mem.wdata = req_byte;
        rx_mem.re    = rx_pop;
        rx_mem.raddr = rx_tail_reg;
    end

    always_comb begin
        stage_next       = stage_reg;
        stage_valid_next = stage_valid_reg;
        if (req_fire) begin
            stage_valid_next    = 1'b1;
            stage_next.line_valid = tx_pop;
            // launch from an empty ring: the byte is the one being written now
            stage_next.tx_fwd   = (tx_fill_reg == '0);
            stage_next.fwd_byte = req_byte;
            stage_next.accepted = tx_push | rx_push | rx_pop;
            stage_next.rd_pop   = rx_pop;
            stage_next.tx_level = to_level(32'(tx_fill_next));
            stage_next.rx_level = to_level(32'(rx_fill_next));
            stage_next.tx_busy  = sending_next;
        end else if (stage_adv) begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_head_reg     <= '0;
            tx_tail_reg     <= '0;
            tx_fill_reg     <= '0;
            rx_head_reg     <= '0;
            rx_tail_reg     <= '0;
            rx_fill_reg     <= '0;
            sending_reg     <= 1'b0;
            stage_valid_reg <= 1'b0;
        end else begin
            tx_head_reg     <= tx_head_next;
            tx_tail_reg     <= tx_tail_next;
            tx_fill_reg     <= tx_fill_next;
            rx_head_reg     <= rx_head_next;
            rx_tail_reg     <= rx_tail_next;
            rx_fill_reg     <= rx_fill_next;
            sending_reg     <= sending_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        stage_reg <= stage_next;
    end

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;

endmodule
